FILE: rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types, constants and tables of the star polygon edge generator.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned NW          = 11;
  localparam int unsigned PhaseW      = 32;
  localparam int unsigned ModSteps    = NW;
  localparam int unsigned PhaseSteps  = PhaseW;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned XyW         = 34;
  localparam int unsigned ZW          = 32;
  localparam int unsigned ProdW       = 66;

  localparam logic signed [XyW-1:0] CordicX0 = 34'sd652032874;

  typedef enum logic [2:0] {
    RegNumPoints = 3'd0,
    RegEdgeStep  = 3'd1,
    RegRadius    = 3'd2,
    RegCenterX   = 3'd3,
    RegCenterY   = 3'd4
  } spe_reg_e;

  typedef struct packed {
    logic [NW-1:0]     rem;
    logic [PhaseW-1:0] quo;
  } spe_div_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } spe_rot_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned j);
    logic signed [ZW-1:0] a;
    case (j)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      24: a = 32'sd41;
      25: a = 32'sd20;
      26: a = 32'sd10;
      27: a = 32'sd5;
      28: a = 32'sd3;
      29: a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/spe_if.sv
// ----------------------------------------------------------------------------
// spe_if
// Valid/ready channels for edge indexes in and polygon edges out.
// ----------------------------------------------------------------------------
interface spe_in_if;
  logic                       valid;
  logic                       ready;
  logic [spe_pkg::IdxW-1:0]   edge_index;
  modport source (output valid, output edge_index, input ready);
  modport sink   (input valid, input edge_index, output ready);
endinterface

interface spe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] from_x;
  logic signed [31:0] from_y;
  logic signed [31:0] to_x;
  logic signed [31:0] to_y;
  logic               index_error;
  modport source (output valid, output from_x, output from_y, output to_x,
                  output to_y, output index_error, input ready);
  modport sink   (input valid, input from_x, input from_y, input to_x,
                  input to_y, input index_error, output ready);
endinterface

FILE: rtl/spe_div_cell.sv
// ----------------------------------------------------------------------------
// spe_div_cell
// One restoring division step: shift in a bit, subtract divisor if it fits.
// ----------------------------------------------------------------------------
module spe_div_cell (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [spe_pkg::NW-1:0] divisor_i,
  input  logic                   bit_i,
  input  spe_pkg::spe_div_t      d_i,
  output spe_pkg::spe_div_t      d_o
);

  logic [spe_pkg::NW-1:0] trial;
  spe_pkg::spe_div_t      d_d, d_q;

  always_comb begin
    trial = {d_i.rem[spe_pkg::NW-2:0], bit_i};
    if (trial >= divisor_i) begin
      d_d.rem = trial - divisor_i;
      d_d.quo = {d_i.quo[spe_pkg::PhaseW-2:0], 1'b1};
    end else begin
      d_d.rem = trial;
      d_d.quo = {d_i.quo[spe_pkg::PhaseW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

FILE: rtl/spe_cordic_cell.sv
// ----------------------------------------------------------------------------
// spe_cordic_cell
// One rotation-mode CORDIC micro-rotation with floor shifts.
// ----------------------------------------------------------------------------
module spe_cordic_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [4:0]                    shift_i,
  input  logic signed [spe_pkg::ZW-1:0] atan_i,
  input  spe_pkg::spe_rot_t             r_i,
  output spe_pkg::spe_rot_t             r_o
);

  logic signed [spe_pkg::XyW-1:0] dx, dy;
  spe_pkg::spe_rot_t              r_d, r_q;

  always_comb begin
    dx = r_i.y >>> shift_i;
    dy = r_i.x >>> shift_i;
    if (!r_i.z[spe_pkg::ZW-1]) begin
      r_d.x = r_i.x - dx;
      r_d.y = r_i.y + dy;
      r_d.z = r_i.z - atan_i;
    end else begin
      r_d.x = r_i.x + dx;
      r_d.y = r_i.y - dy;
      r_d.z = r_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

FILE: rtl/star_polygon_edge_generator_core.sv
// ----------------------------------------------------------------------------
// star_polygon_edge_generator_core
// Edge of a regular star polygon for an edge index, Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Send an edge index on in_i; one edge item comes back on out_o with the
// start vertex, the end vertex (index + edge_step mod N) and an error flag
// for an index not below N (coordinates then zero).
// The datapath is a row of cells: 11 restoring-division cells for the end
// index, 32 per lane for the phase k/N of both vertices, 30 CORDIC cells per
// lane, one multiply stage and one round/saturate stage into the output
// register. One item is taken every cycle while the row advances, set by the
// one-step-per-cell chains.
// All cells advance together while the output register is empty or being
// taken; when the receiver stalls with a result waiting, the whole row
// holds and in_i.ready drops until the result is taken.
// Reset clears all valid bits and loads the register defaults (N = 5,
// step 2, radius 1.0, center at the origin). Write registers over APB only
// while no item is in flight; registers sit at byte address 4*index.
// ----------------------------------------------------------------------------
module star_polygon_edge_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  spe_in_if.sink      in_i,
  spe_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NW  = spe_pkg::NW;
  localparam int unsigned IW  = spe_pkg::IdxW;
  localparam int unsigned MS  = spe_pkg::ModSteps;
  localparam int unsigned PS  = spe_pkg::PhaseSteps;
  localparam int unsigned CS  = spe_pkg::CordicSteps;
  localparam int unsigned XW  = spe_pkg::XyW;
  localparam int unsigned PW  = spe_pkg::ProdW;

  // Configuration registers
  logic [NW-1:0]      num_points_q;
  logic [IW-1:0]      edge_step_q;
  logic [30:0]        radius_q;
  logic signed [31:0] center_x_q, center_y_q;
  logic               wr_en;
  spe_pkg::spe_reg_e  wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = spe_pkg::spe_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NW'(5);
      edge_step_q  <= IW'(2);
      radius_q     <= 31'd65536;
      center_x_q   <= '0;
      center_y_q   <= '0;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (wr_idx)
        spe_pkg::RegNumPoints: num_points_q <= pwdata[NW-1:0];
        spe_pkg::RegEdgeStep:  edge_step_q  <= pwdata[IW-1:0];
        spe_pkg::RegRadius:    radius_q     <= pwdata[30:0];
        spe_pkg::RegCenterX:   center_x_q   <= pwdata;
        spe_pkg::RegCenterY:   center_y_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      spe_pkg::RegNumPoints: prdata = {21'd0, num_points_q};
      spe_pkg::RegEdgeStep:  prdata = {22'd0, edge_step_q};
      spe_pkg::RegRadius:    prdata = {1'b0, radius_q};
      spe_pkg::RegCenterX:   prdata = center_x_q;
      spe_pkg::RegCenterY:   prdata = center_y_q;
      default:               prdata = '0;
    endcase
  end

  // Global advance: move the row when the output slot is free or drained
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Input stage: clamp N, flag range errors, form index + step
  logic [NW-1:0] n_eff;
  logic          s0_valid_q, s0_err_q;
  logic [IW-1:0] s0_idx_q;
  logic [NW-1:0] s0_n_q, s0_sum_q;

  assign n_eff = (num_points_q > NW'(spe_pkg::MaxPoints)) ?
                 NW'(spe_pkg::MaxPoints) : num_points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_idx_q <= in_i.edge_index;
      s0_n_q   <= n_eff;
      s0_err_q <= {1'b0, in_i.edge_index} >= n_eff;
      s0_sum_q <= {1'b0, in_i.edge_index} + {1'b0, edge_step_q};
    end
  end

  // End index: (i + step) mod N through restoring division cells
  spe_pkg::spe_div_t mod_d [MS];
  logic              mod_v_q   [MS];
  logic              mod_err_q [MS];
  logic [IW-1:0]     mod_idx_q [MS];
  logic [NW-1:0]     mod_n_q   [MS];
  logic [NW-1:0]     mod_sum_q [MS];

  for (genvar j = 0; j < MS; j++) begin : g_mod
    spe_pkg::spe_div_t cin;
    logic [NW-1:0]     div_in, sum_in;
    if (j == 0) begin : g_first
      assign cin    = '0;
      assign div_in = s0_n_q;
      assign sum_in = s0_sum_q;
    end else begin : g_next
      assign cin    = mod_d[j-1];
      assign div_in = mod_n_q[j-1];
      assign sum_in = mod_sum_q[j-1];
    end
    spe_div_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (en),
      .divisor_i (div_in),
      .bit_i     (sum_in[NW-1-j]),
      .d_i       (cin),
      .d_o       (mod_d[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MS; j++) mod_v_q[j] <= 1'b0;
    end else if (en) begin
      mod_v_q[0] <= s0_valid_q;
      for (int j = 1; j < MS; j++) mod_v_q[j] <= mod_v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mod_err_q[0] <= s0_err_q;
      mod_idx_q[0] <= s0_idx_q;
      mod_n_q[0]   <= s0_n_q;
      mod_sum_q[0] <= s0_sum_q;
      for (int j = 1; j < MS; j++) begin
        mod_err_q[j] <= mod_err_q[j-1];
        mod_idx_q[j] <= mod_idx_q[j-1];
        mod_n_q[j]   <= mod_n_q[j-1];
        mod_sum_q[j] <= mod_sum_q[j-1];
      end
    end
  end

  // Phase: floor((k * 2^32 + floor(N/2)) / N), one quotient bit per cell
  spe_pkg::spe_div_t pa_d [PS];
  spe_pkg::spe_div_t pb_d [PS];
  logic              ph_v_q   [PS];
  logic              ph_err_q [PS];
  logic [NW-1:0]     ph_n_q   [PS];

  for (genvar j = 0; j < PS; j++) begin : g_ph
    spe_pkg::spe_div_t ain, bin;
    logic [NW-1:0]     div_in;
    logic [31:0]       half;
    if (j == 0) begin : g_first
      assign ain    = '{rem: {1'b0, mod_idx_q[MS-1]}, quo: '0};
      assign bin    = '{rem: {1'b0, mod_d[MS-1].rem[IW-1:0]}, quo: '0};
      assign div_in = mod_n_q[MS-1];
    end else begin : g_next
      assign ain    = pa_d[j-1];
      assign bin    = pb_d[j-1];
      assign div_in = ph_n_q[j-1];
    end
    assign half = {22'd0, div_in[NW-1:1]};
    spe_div_cell u_a (
      .clk_i     (clk_i),
      .en_i      (en),
      .divisor_i (div_in),
      .bit_i     (half[31-j]),
      .d_i       (ain),
      .d_o       (pa_d[j])
    );
    spe_div_cell u_b (
      .clk_i     (clk_i),
      .en_i      (en),
      .divisor_i (div_in),
      .bit_i     (half[31-j]),
      .d_i       (bin),
      .d_o       (pb_d[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < PS; j++) ph_v_q[j] <= 1'b0;
    end else if (en) begin
      ph_v_q[0] <= mod_v_q[MS-1];
      for (int j = 1; j < PS; j++) ph_v_q[j] <= ph_v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_err_q[0] <= mod_err_q[MS-1];
      ph_n_q[0]   <= mod_n_q[MS-1];
      for (int j = 1; j < PS; j++) begin
        ph_err_q[j] <= ph_err_q[j-1];
        ph_n_q[j]   <= ph_n_q[j-1];
      end
    end
  end

  // Split the phase into nearest quadrant and signed residual
  logic [31:0] pha, phb, rnda, rndb;
  logic [1:0]  qa, qb;
  logic [31:0] za, zb;

  assign pha  = pa_d[PS-1].quo;
  assign phb  = pb_d[PS-1].quo;
  assign rnda = pha + 32'h2000_0000;
  assign rndb = phb + 32'h2000_0000;
  assign qa   = rnda[31:30];
  assign qb   = rndb[31:30];
  assign za   = pha - {qa, 30'd0};
  assign zb   = phb - {qb, 30'd0};

  // CORDIC lanes
  spe_pkg::spe_rot_t ra [CS];
  spe_pkg::spe_rot_t rb [CS];
  logic              co_v_q   [CS];
  logic              co_err_q [CS];
  logic [1:0]        co_qa_q  [CS];
  logic [1:0]        co_qb_q  [CS];

  for (genvar j = 0; j < CS; j++) begin : g_co
    spe_pkg::spe_rot_t ain, bin;
    if (j == 0) begin : g_first
      assign ain = '{x: spe_pkg::CordicX0, y: '0, z: $signed(za)};
      assign bin = '{x: spe_pkg::CordicX0, y: '0, z: $signed(zb)};
    end else begin : g_next
      assign ain = ra[j-1];
      assign bin = rb[j-1];
    end
    spe_cordic_cell u_a (
      .clk_i   (clk_i),
      .en_i    (en),
      .shift_i (5'(j)),
      .atan_i  (spe_pkg::atan_turn(j)),
      .r_i     (ain),
      .r_o     (ra[j])
    );
    spe_cordic_cell u_b (
      .clk_i   (clk_i),
      .en_i    (en),
      .shift_i (5'(j)),
      .atan_i  (spe_pkg::atan_turn(j)),
      .r_i     (bin),
      .r_o     (rb[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CS; j++) co_v_q[j] <= 1'b0;
    end else if (en) begin
      co_v_q[0] <= ph_v_q[PS-1];
      for (int j = 1; j < CS; j++) co_v_q[j] <= co_v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      co_err_q[0] <= ph_err_q[PS-1];
      co_qa_q[0]  <= qa;
      co_qb_q[0]  <= qb;
      for (int j = 1; j < CS; j++) begin
        co_err_q[j] <= co_err_q[j-1];
        co_qa_q[j]  <= co_qa_q[j-1];
        co_qb_q[j]  <= co_qb_q[j-1];
      end
    end
  end

  // Apply the quadrant rotation exactly, then scale by the radius
  logic signed [XW-1:0] ca, sa, cb, sb;

  always_comb begin
    case (co_qa_q[CS-1])
      2'd0:    begin ca = ra[CS-1].x;  sa = ra[CS-1].y;  end
      2'd1:    begin ca = -ra[CS-1].y; sa = ra[CS-1].x;  end
      2'd2:    begin ca = -ra[CS-1].x; sa = -ra[CS-1].y; end
      default: begin ca = ra[CS-1].y;  sa = -ra[CS-1].x; end
    endcase
    case (co_qb_q[CS-1])
      2'd0:    begin cb = rb[CS-1].x;  sb = rb[CS-1].y;  end
      2'd1:    begin cb = -rb[CS-1].y; sb = rb[CS-1].x;  end
      2'd2:    begin cb = -rb[CS-1].x; sb = -rb[CS-1].y; end
      default: begin cb = rb[CS-1].y;  sb = -rb[CS-1].x; end
    endcase
  end

  logic                 mu_v_q, mu_err_q;
  logic signed [PW-1:0] p_fx_q, p_fy_q, p_tx_q, p_ty_q;
  logic signed [31:0]   rad_s;

  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_v_q <= 1'b0;
    end else if (en) begin
      mu_v_q <= co_v_q[CS-1];
    end
  end

  // Widen both factors first so the full product is kept
  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_err_q <= co_err_q[CS-1];
      p_fx_q   <= PW'(rad_s) * PW'(ca);
      p_fy_q   <= PW'(rad_s) * PW'(sa);
      p_tx_q   <= PW'(rad_s) * PW'(cb);
      p_ty_q   <= PW'(rad_s) * PW'(sb);
    end
  end

  // Round half up, offset by the center, saturate to 32 bits
  function automatic logic signed [31:0] place(input logic signed [PW-1:0] p,
                                               input logic signed [31:0] c);
    logic signed [PW:0]   rp;
    logic signed [PW-30:0] sh;
    logic signed [PW-29:0] sum;
    rp  = {p[PW-1], p} + (PW+1)'(33'sh0_2000_0000);
    sh  = rp[PW:30];
    sum = {sh[PW-30], sh} + (PW-28)'(c);
    if (sum > (PW-28)'(33'sh0_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (sum < -(PW-28)'(33'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end
    return sum[31:0];
  endfunction

  logic signed [31:0] fx_q, fy_q, tx_q, ty_q;
  logic               err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q <= mu_err_q;
      fx_q  <= mu_err_q ? '0 : place(p_fx_q, center_x_q);
      fy_q  <= mu_err_q ? '0 : place(p_fy_q, center_y_q);
      tx_q  <= mu_err_q ? '0 : place(p_tx_q, center_x_q);
      ty_q  <= mu_err_q ? '0 : place(p_ty_q, center_y_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.from_x      = fx_q;
  assign out_o.from_y      = fy_q;
  assign out_o.to_x        = tx_q;
  assign out_o.to_y        = ty_q;
  assign out_o.index_error = err_q;

  // Error items carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> fx_q == 0 && fy_q == 0 && tx_q == 0 && ty_q == 0)
    else $error("error item with nonzero coordinates");

  // An accepted index enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s0_valid_q)
    else $error("accepted index lost at input stage");

  // A stalled result holds the whole row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(fx_q) && $stable(mu_v_q))
    else $error("pipeline moved while output stalled");

  // Vertex count write lands in its register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && paddr == {spe_pkg::RegNumPoints, 2'b00} |=>
      num_points_q == $past(pwdata[NW-1:0]))
    else $error("num_points write not taken");

endmodule

FILE: test/tb_star_polygon_edge_generator_core.sv
// ----------------------------------------------------------------------------
// tb_star_polygon_edge_generator_core
// Self-checking bench: edge indexes go in over a valid/ready channel under
// bursty traffic and receiver stalls, and every edge item that comes out is
// compared against a bit-exact CORDIC model of the star polygon vertices.
// Registers are set over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_star_polygon_edge_generator_core;

  // One edge item as the block should produce it.
  typedef struct {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic               index_error;
  } edge_item_t;

  // Holds a mirror of the registers, computes the edge for each accepted
  // index and keeps the edges still owed by the block, oldest first.
  class edge_scoreboard;
    logic [10:0]        npts;
    logic [9:0]         step;
    logic [30:0]        rad;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    edge_item_t         owed[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        err_seen;
    longint             atan_tab[30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

    function void reset_regs();
      npts = 11'd5;
      step = 10'd2;
      rad  = 31'd65536;
      cx   = '0;
      cy   = '0;
    endfunction

    function void write_reg(spe_pkg::spe_reg_e idx, logic [31:0] val);
      case (idx)
        spe_pkg::RegNumPoints: npts = val[10:0];
        spe_pkg::RegEdgeStep:  step = val[9:0];
        spe_pkg::RegRadius:    rad  = val[30:0];
        spe_pkg::RegCenterX:   cx   = val;
        spe_pkg::RegCenterY:   cy   = val;
        default: ;
      endcase
    endfunction

    function int unsigned eff_points();
      return (npts > spe_pkg::MaxPoints) ? spe_pkg::MaxPoints : npts;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Vertex k of n: phase as a fraction of a turn, nearest quadrant, CORDIC
    // on the residual, then scale by the radius and offset by the center.
    function void vertex(int unsigned k, int unsigned n,
                         output logic signed [31:0] px,
                         output logic signed [31:0] py);
      longint unsigned num;
      logic [31:0]     phase, q, resid;
      longint          x, y, z, dx, dy, c, s;
      num   = (longint'(k) << 32) + longint'(n / 2);
      phase = 32'(num / longint'(n));
      q     = ((phase + 32'h2000_0000) >> 30) & 32'd3;
      resid = phase - (q << 30);
      z     = longint'(signed'(resid));
      x     = 652032874;
      y     = 0;
      for (int j = 0; j < 30; j++) begin
        dx = y >>> j;
        dy = x >>> j;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[j];
        end else begin
          x += dx; y -= dy; z += atan_tab[j];
        end
      end
      case (q)
        0: begin c = x;  s = y;  end
        1: begin c = -y; s = x;  end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      px = clamp32(longint'(cx) + ((longint'(rad) * c + 64'sd536870912) >>> 30));
      py = clamp32(longint'(cy) + ((longint'(rad) * s + 64'sd536870912) >>> 30));
    endfunction

    function void note_index(logic [9:0] idx);
      edge_item_t  e;
      int unsigned n;
      n = eff_points();
      if (idx >= n) begin
        e = '{0, 0, 0, 0, 1'b1};
      end else begin
        vertex(32'(idx), n, e.from_x, e.from_y);
        vertex((32'(idx) + 32'(step)) % n, n, e.to_x, e.to_y);
        e.index_error = 1'b0;
      end
      owed = {owed, e};
    endfunction

    function void check_edge(edge_item_t got);
      edge_item_t w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected edge item, nothing owed", $time);
        errors++;
        return;
      end
      w = owed.pop_front();
      checked++;
      if (got.index_error) err_seen++;
      if (got.from_x !== w.from_x) begin
        $display("%0t: from_x expected %0d got %0d", $time, w.from_x, got.from_x);
        errors++;
      end
      if (got.from_y !== w.from_y) begin
        $display("%0t: from_y expected %0d got %0d", $time, w.from_y, got.from_y);
        errors++;
      end
      if (got.to_x !== w.to_x) begin
        $display("%0t: to_x expected %0d got %0d", $time, w.to_x, got.to_x);
        errors++;
      end
      if (got.to_y !== w.to_y) begin
        $display("%0t: to_y expected %0d got %0d", $time, w.to_y, got.to_y);
        errors++;
      end
      if (got.index_error !== w.index_error) begin
        $display("%0t: index_error expected %0b got %0b", $time,
                 w.index_error, got.index_error);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  spe_in_if  idx_ch();
  spe_out_if edge_ch();

  star_polygon_edge_generator_core dut (
    .clk_i, .rst_ni, .in_i(idx_ch.sink), .out_o(edge_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  edge_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    sent = 0;
  int unsigned    cycle = 0;
  int unsigned    cfg_writes = 0;

  always #2 clk_i = ~clk_i;

  initial begin
    idx_ch.valid      = 1'b0;
    idx_ch.edge_index = '0;
    edge_ch.ready     = 1'b0;
  end

  // Receiver stall pattern: the mode steps in turn through always ready,
  // mostly ready, sparse and long stalls.
  always @(negedge clk_i) begin
    cycle <= cycle + 1;
    case ((cycle >> 8) % 4)
      0: edge_ch.ready <= 1'b1;
      1: edge_ch.ready <= ($urandom_range(0, 9) < 7);
      2: edge_ch.ready <= ($urandom_range(0, 3) == 0);
      default: edge_ch.ready <= ((cycle % 40) > 30);
    endcase
  end

  // Sample the output just ahead of each rising edge, once inputs settled.
  always @(negedge clk_i) begin
    edge_item_t got;
    #1;
    if (rst_ni && edge_ch.valid && edge_ch.ready) begin
      got.from_x      = edge_ch.from_x;
      got.from_y      = edge_ch.from_y;
      got.to_x        = edge_ch.to_x;
      got.to_y        = edge_ch.to_y;
      got.index_error = edge_ch.index_error;
      @(posedge clk_i);
      sb.check_edge(got);
    end
  end

  // Setup cycle, access cycle, then drop the select.
  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    sb.write_reg(spe_pkg::spe_reg_e'(idx), val);
    cfg_writes++;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Send one index; idle a random gap at the start of each burst.
  task automatic send_index(logic [9:0] idx);
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      @(negedge clk_i);
      idx_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    burst_left--;
    idx_ch.valid      = 1'b1;
    idx_ch.edge_index = idx;
    do begin
      #1;
      taken = idx_ch.ready;
      @(posedge clk_i);
      if (!taken) @(negedge clk_i);
    end while (!taken);
    sb.note_index(idx);
    sent++;
  endtask

  // Drop valid, wait for every owed edge, then let the pipe run empty.
  task automatic drain();
    @(negedge clk_i);
    idx_ch.valid = 1'b0;
    burst_left   = 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] n, logic [31:0] st, logic [31:0] r,
                          logic [31:0] x, logic [31:0] y);
    apb_write(spe_pkg::RegNumPoints, n);
    apb_write(spe_pkg::RegEdgeStep, st);
    apb_write(spe_pkg::RegRadius, r);
    apb_write(spe_pkg::RegCenterX, x);
    apb_write(spe_pkg::RegCenterY, y);
  endtask

  function automatic logic [9:0] pick_index();
    int unsigned n;
    n = sb.eff_points();
    if (n > 0 && $urandom_range(0, 9) < 8) return 10'($urandom_range(0, n - 1));
    return 10'($urandom());
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom();
      default: return $urandom_range(0, 200) * 65536 - 100 * 65536;
    endcase
  endfunction

  initial begin
    logic [31:0] n, r;
    sb.reset_regs();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: a pentagram, plus indexes past N.
    for (int i = 0; i < 5; i++) send_index(10'(i));
    send_index(10'd5);
    send_index(10'd1023);
    drain();

    // Full vertex count, largest step, saturating radius and center.
    set_regs(32'd1024, 32'd1023, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_index(10'd0); send_index(10'd1023); send_index(10'd256);
    send_index(10'd512); send_index(10'd768); send_index(10'd1);
    drain();

    // Zero vertices: every index is out of range.
    set_regs(32'd0, 32'd0, 32'd0, 32'h80000000, 32'h7fffffff);
    send_index(10'd0); send_index(10'd1023);
    drain();

    // Vertex count above the maximum clamps to it; unknown register ignored.
    apb_write(3'd5, 32'hffffffff);
    apb_write(3'd7, 32'h12345678);
    set_regs(32'd2047, 32'd700, 32'd65536 * 100, 32'd0, 32'd0);
    send_index(10'd1023); send_index(10'd3);
    drain();

    // Single vertex, zero step; then three vertices with a step above N.
    set_regs(32'd1, 32'd0, 32'd65536, 32'd0, 32'd0);
    send_index(10'd0); send_index(10'd1);
    drain();
    set_regs(32'd3, 32'd1000, 32'd65536 * 3, 32'd65536, 32'hffff0000);
    send_index(10'd0); send_index(10'd1); send_index(10'd2);
    drain();

    // Random phases: fresh registers, then a run of mostly valid indexes.
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 5))
        0: n = $urandom_range(1025, 2047);
        1: n = 0;
        2: n = 1024;
        3: n = $urandom_range(1, 12);
        default: n = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 3))
        0: r = 32'h7fffffff;
        1: r = 0;
        2: r = $urandom();
        default: r = $urandom_range(1, 500) * 65536 + $urandom_range(0, 65535);
      endcase
      set_regs(n, $urandom(), r, pick_coord(), pick_coord());
      for (int k = 0; k < 100; k++) send_index(pick_index());
      drain();
    end

    $display("Sent %0d edge indexes, checked %0d edge items (%0d out of range),",
             sent, sb.checked, sb.err_seen);
    $display("over %0d register writes under bursty input and stalled output.",
             cfg_writes);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS star_polygon_edge_generator_core");
    end else begin
      $display("FAIL star_polygon_edge_generator_core");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d edge items still owed", sb.owed.size());
    $display("FAIL star_polygon_edge_generator_core");
    $finish;
  end

endmodule
